### hdl/mbfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfs_pkg
// Shared types and constants of the msb-first bit-field stream block.
// ----------------------------------------------------------------------------
package mbfs_pkg;

    localparam int LEN_W          = 13;
    localparam int MAX_FIELD_BITS = 32;
    localparam int WIN_BITS       = 40;   // five bytes cover any field

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

    // commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_JUMP  = 2'd2;
    localparam logic [1:0] CMD_MOVE  = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_COUNT  = 3'd1;
    localparam logic [2:0] ST_PAST_END   = 3'd2;
    localparam logic [2:0] ST_BAD_TARGET = 3'd3;
    localparam logic [2:0] ST_MOVE_NEG   = 3'd4;
    localparam logic [2:0] ST_MOVE_PAST  = 3'd5;

    // one classified command, handed from the front to the back
    typedef struct packed {
        logic             is_write;
        logic [2:0]       nbytes;    // bytes touched, zero when no memory access
        logic [LEN_W-1:0] base;      // first byte touched
        logic [2:0]       bit0;      // first bit within that byte
        logic [5:0]       count;
        logic [2:0]       tail;      // unused bits after the field in its last byte
        logic [31:0]      wval;
        logic [2:0]       status;
        logic [LEN_W-1:0] cur_byte;
        logic [2:0]       cur_bit;
    } t_job;

endpackage

### hdl/msb_first_bit_field_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_field_stream
// Bit cursor over a byte store: msb-first field read and write, absolute
// jump and relative move, each answered by one result transaction.
//
//   channel   direction  handshake                 payload
//   command   in         i_in_valid / o_in_ready   i_cmd .. i_delta_bits
//   result    out        o_out_valid / i_out_ready o_read_data .. o_cursor_bit
//   config    in         i_cfg_wr_en               i_cfg_wr_data
//
// a read or write touching n bytes (1 to 5) reads them one byte at a time in
// the back end, bounded by the one byte-wide read port of the store; jump,
// move and rejected commands touch no bytes and go straight to the result
// the front checks a command in its accept cycle and queues up to two
// synchronous active-low reset clears cursor, queue and result; length
// returns to 4096, store contents are unknown until written
// a stalled result holds the back end; the queue then fills and stalls input
// ----------------------------------------------------------------------------
module msb_first_bit_field_stream import mbfs_pkg::*; #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LEN_W-1:0]   i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [5:0]         i_bit_count,
    input  logic [31:0]        i_write_value,
    input  logic [LEN_W-1:0]   i_target_byte,
    input  logic [3:0]         i_target_bit,
    input  logic signed [16:0] i_delta_bytes,
    input  logic signed [15:0] i_delta_bits,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_read_data,
    output logic [2:0]         o_status,
    output logic [LEN_W-1:0]   o_cursor_byte,
    output logic [2:0]         o_cursor_bit
);

    logic w_push;
    t_job w_push_job;
    logic w_q_full;
    logic w_q_valid;
    logic w_pop;
    t_job w_head_job;

    mbfs_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_bit_count   (i_bit_count),
        .i_write_value (i_write_value),
        .i_target_byte (i_target_byte),
        .i_target_bit  (i_target_bit),
        .i_delta_bytes (i_delta_bytes),
        .i_delta_bits  (i_delta_bits),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    mbfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_head_job)
    );

    mbfs_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_q_valid),
        .i_job         (w_head_job),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_status      (o_status),
        .o_cursor_byte (o_cursor_byte),
        .o_cursor_bit  (o_cursor_bit)
    );

endmodule

### hdl/mbfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/mbfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfs_front
// Accepts commands, owns the cursor and length, checks each command and
// queues it with its status and resulting cursor.
// ----------------------------------------------------------------------------
module mbfs_front import mbfs_pkg::*; #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [LEN_W-1:0]  i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    input  logic [5:0]        i_bit_count,
    input  logic [31:0]       i_write_value,
    input  logic [LEN_W-1:0]  i_target_byte,
    input  logic [3:0]        i_target_bit,
    input  logic signed [16:0] i_delta_bytes,
    input  logic signed [15:0] i_delta_bits,
    input  logic              i_q_full,
    output logic              o_push,
    output t_job              o_job
);

    logic [LEN_W-1:0] r_length;
    logic [LEN_W-1:0] r_cur_byte;
    logic [2:0]       r_cur_bit;

    logic [LEN_W-1:0]   w_len_eff;
    logic [LEN_W+2:0]   w_pos;
    logic [LEN_W+3:0]   w_end;
    logic [LEN_W+3:0]   w_limit;
    logic [6:0]         w_span;
    logic signed [21:0] w_pos_s;
    logic signed [21:0] w_dbyte_s;
    logic signed [21:0] w_dbit_s;
    logic signed [21:0] w_total;
    logic               w_accept;
    t_job               w_job;

    always_comb begin
        if (32'(r_length) > BUFFER_BYTES) begin
            w_len_eff = LEN_W'(BUFFER_BYTES);
        end else begin
            w_len_eff = r_length;
        end
    end

    assign w_pos   = {r_cur_byte, r_cur_bit};
    assign w_end   = {1'b0, w_pos} + (LEN_W+4)'(i_bit_count);
    assign w_limit = {1'b0, w_len_eff, 3'b000};
    assign w_span  = 7'(r_cur_bit) + 7'(i_bit_count);

    // move: position plus eight times the byte delta plus the bit delta
    assign w_pos_s   = signed'({6'b0, w_pos});
    assign w_dbyte_s = signed'({{2{i_delta_bytes[16]}}, i_delta_bytes, 3'b000});
    assign w_dbit_s  = signed'({{6{i_delta_bits[15]}}, i_delta_bits});
    assign w_total   = w_pos_s + w_dbyte_s + w_dbit_s;

    always_comb begin
        w_job          = '0;
        w_job.wval     = i_write_value;
        w_job.count    = i_bit_count;
        w_job.base     = r_cur_byte;
        w_job.bit0     = r_cur_bit;
        w_job.tail     = 3'(7'd0 - w_span);
        w_job.status   = ST_OK;
        w_job.cur_byte = r_cur_byte;
        w_job.cur_bit  = r_cur_bit;
        unique case (i_cmd)
            CMD_READ, CMD_WRITE: begin
                priority if (i_bit_count == 6'd0
                             || i_bit_count > 6'(MAX_FIELD_BITS)) begin
                    w_job.status = ST_BAD_COUNT;
                end else if (w_end > w_limit) begin
                    w_job.status = ST_PAST_END;
                end else begin
                    w_job.is_write = (i_cmd == CMD_WRITE);
                    w_job.nbytes   = 3'((w_span + 7'd7) >> 3);
                    w_job.cur_byte = w_end[LEN_W+2:3];
                    w_job.cur_bit  = w_end[2:0];
                end
            end
            CMD_JUMP: begin
                if (i_target_byte > w_len_eff || i_target_bit > 4'd7) begin
                    w_job.status = ST_BAD_TARGET;
                end else begin
                    w_job.cur_byte = i_target_byte;
                    w_job.cur_bit  = i_target_bit[2:0];
                end
            end
            CMD_MOVE: begin
                priority if (w_total[21]) begin
                    w_job.status = ST_MOVE_NEG;
                end else if (w_total[21:3] > {6'b0, w_len_eff}) begin
                    w_job.status = ST_MOVE_PAST;
                end else begin
                    w_job.cur_byte = w_total[LEN_W+2:3];
                    w_job.cur_bit  = w_total[2:0];
                end
            end
        endcase
    end

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = w_accept;
    assign o_job      = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length   <= LEN_RESET;
            r_cur_byte <= '0;
            r_cur_bit  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_length <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_cur_byte <= w_job.cur_byte;
                r_cur_bit  <= w_job.cur_bit;
            end
        end
    end

    // the cursor only moves with an accepted transaction
    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_cur_byte) && $stable(r_cur_bit))
        else $error("cursor changed without a transaction");

endmodule

### hdl/mbfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfs_queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module mbfs_queue import mbfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_job             r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_entry[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PTR_W+1)'(w_push) - (PTR_W+1)'(w_pop);
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(DEPTH))
        else $error("queue count out of range");

endmodule

### hdl/mbfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfs_back
// Executes queued commands on the byte store: byte reads for a field read,
// read-modify-write per byte for a field write, then the result register.
// ----------------------------------------------------------------------------
module mbfs_back import mbfs_pkg::*; #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [31:0]      o_read_data,
    output logic [2:0]       o_status,
    output logic [LEN_W-1:0] o_cursor_byte,
    output logic [2:0]       o_cursor_bit
);

    localparam int AW = $clog2(BUFFER_BYTES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          r_state;
    t_job                r_job;
    logic [2:0]          r_ic;
    logic [2:0]          r_dc;
    logic                r_rvalid;
    logic [WIN_BITS-1:0] r_acc;
    logic [WIN_BITS-1:0] r_wv;
    logic [WIN_BITS-1:0] r_wm;
    logic [31:0]         r_mask;

    logic                r_out_valid;
    logic [31:0]         r_read_data;
    logic [2:0]          r_status;
    logic [LEN_W-1:0]    r_cursor_byte;
    logic [2:0]          r_cursor_bit;

    logic [31:0]         w_mask32;
    logic [5:0]          w_wsh;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic                w_we;
    logic [AW-1:0]       w_wr_addr;
    logic [7:0]          w_wr_data;
    logic [7:0]          w_rd_data;
    logic                w_out_free;

    assign w_mask32 = 32'((33'd1 << i_job.count) - 33'd1);
    // left-align the field in the five-byte window after its start bit
    assign w_wsh    = 6'(7'd40 - 7'(i_job.bit0) - 7'(i_job.count));

    assign o_pop      = (r_state == S_IDLE) && i_job_valid;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_rd_en   = (r_state == S_RUN) && (r_ic < r_job.nbytes);
    assign w_rd_addr = AW'(r_job.base + LEN_W'(r_ic));
    assign w_we      = r_rvalid && r_job.is_write;
    assign w_wr_addr = AW'(r_job.base + LEN_W'(r_dc));
    assign w_wr_data = (w_rd_data & ~r_wm[WIN_BITS-1 -: 8])
                     | (r_wv[WIN_BITS-1 -: 8] & r_wm[WIN_BITS-1 -: 8]);

    mbfs_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_acc  <= '0;
            r_mask <= w_mask32;
            r_wv   <= {8'b0, i_job.wval & w_mask32} << w_wsh;
            r_wm   <= {8'b0, w_mask32} << w_wsh;
        end else if (r_rvalid) begin
            if (!r_job.is_write) begin
                r_acc <= {r_acc[WIN_BITS-9:0], w_rd_data};
            end
            r_wv <= r_wv << 8;
            r_wm <= r_wm << 8;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_read_data   <= 32'(r_acc >> r_job.tail) & r_mask;
            r_status      <= r_job.status;
            r_cursor_byte <= r_job.cur_byte;
            r_cursor_bit  <= r_job.cur_bit;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ic        <= '0;
            r_dc        <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rvalid <= w_rd_en;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_ic    <= '0;
                        r_dc    <= '0;
                        r_state <= (i_job.nbytes == 3'd0) ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_rd_en) begin
                        r_ic <= r_ic + 3'd1;
                    end
                    if (r_rvalid) begin
                        r_dc <= r_dc + 3'd1;
                        if (r_dc == r_job.nbytes - 3'd1) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_status      = r_status;
    assign o_cursor_byte = r_cursor_byte;
    assign o_cursor_bit  = r_cursor_bit;

    a_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_RUN) && r_job.is_write)
        else $error("store written outside a field write");

    a_data_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvalid |-> (r_dc < r_ic))
        else $error("read data without a matching read");

    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && w_out_free |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished transaction not presented");

endmodule
